@@ hw/rtl/plmap_pkg.sv @@
package plmap_pkg;

  // Table depth default and fixed datapath widths.
  localparam int unsigned DefMaxPoints = 16;
  localparam int VW = 16;          // Q8.8 value width
  localparam int XW = VW + 2;      // differences and mirrored inputs
  localparam int PW = 2 * XW;      // product width
  localparam int QW = PW + 1;      // signed quotient width
  localparam int SW = PW + 4;      // final sum width
  localparam int EW = 2 * VW;      // one stored breakpoint {thrust, speed}
  localparam int AddrW = 4;        // APB byte address width

  // Default limits are -100 and 100 in Q8.8.
  localparam int DefLimitUnits = 100;
  localparam logic signed [VW-1:0] DefLowLimit  = VW'(-DefLimitUnits * 256);
  localparam logic signed [VW-1:0] DefHighLimit = VW'(DefLimitUnits * 256);

  localparam logic signed [SW-1:0] SatHi = SW'(32767);
  localparam logic signed [SW-1:0] SatLo = -SW'(32768);

  // Request codes.
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_SPEED  = 2'd2;
  localparam logic [1:0] REQ_THRUST = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_SIGN   = 3'd2;
  localparam logic [2:0] ST_NONASC = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_ORDER  = 3'd5;

  // Register indexes.
  localparam logic [1:0] REG_LOW    = 2'd0;
  localparam logic [1:0] REG_HIGH   = 2'd1;
  localparam logic [1:0] REG_FACTOR = 2'd2;
  localparam logic [1:0] REG_MIRROR = 2'd3;

endpackage

@@ hw/rtl/plmap_div.sv @@
module plmap_div
  import plmap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [PW-1:0] num_i,
  input  logic signed [XW-1:0] den_i,
  output logic                 done_o,
  output logic signed [QW-1:0] quo_o
);

  localparam int CntW = $clog2(PW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [PW-1:0]   num_q;
  logic [XW-2:0]   den_q;
  logic [XW-2:0]   rem_q;
  logic            neg_q;

  logic [PW-1:0]   num_mag;
  logic [XW-1:0]   den_abs;
  logic [XW-1:0]   rem_sh;
  logic [XW:0]     trial;
  logic            ge;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign num_mag = num_i[PW-1] ? PW'(-num_i) : PW'(num_i);
  assign den_abs = den_i[XW-1] ? XW'(-den_i) : XW'(den_i);
  assign rem_sh  = {rem_q, num_q[PW-1]};
  assign trial   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge      = !trial[XW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(PW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_mag;
      den_q <= den_abs[XW-2:0];
      rem_q <= '0;
      neg_q <= num_i[PW-1] ^ den_i[XW-1];
    end else if (busy_q) begin
      rem_q <= ge ? trial[XW-2:0] : rem_sh[XW-2:0];
      num_q <= {num_q[PW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

@@ hw/rtl/piecewise_linear_thrust_speed_map.sv @@
// Piecewise-linear thrust/speed map.
// Input channel (in_valid_i/in_ready_o) carries one transaction per request:
// clear the tables, append a {thrust, speed} breakpoint, ask for speed from
// thrust, or ask for thrust from speed. The output channel (out_valid_o /
// out_ready_i) returns exactly one transaction per request with the Q8.8
// value and a status code. Registers sit on a small APB port.
// A query walks the breakpoint table through one registered memory read port,
// one visited entry at a time, then runs one multiply and a shared restoring
// divider that produces one quotient bit per cycle.
// One request is worked at a time; in_ready_o is high only while the sequencer
// is idle. A finished result waits in the output register, so a new request
// can be accepted while the receiver stalls; that request then finishes and
// waits until the output register is free.
// Reset empties both tables and loads the default limits; table contents are
// not cleared, since only entries below the counts are ever read.
module piecewise_linear_thrust_speed_map
  import plmap_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DefMaxPoints
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic signed [VW-1:0] thrust_in_i,
  input  logic signed [VW-1:0] speed_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [VW-1:0] value_out_o,
  output logic [2:0]           status_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_EV   = 4'd2;
  localparam logic [3:0] S_APP  = 4'd3;
  localparam logic [3:0] S_SEG  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DST  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // Configuration registers.
  logic signed [VW-1:0] cfg_low_q, cfg_high_q;
  logic [VW-1:0]        cfg_factor_q;
  logic                 cfg_mirror_q;
  logic                 cfg_wr;

  // Control state.
  logic [3:0]    state_q, state_d;
  logic [CW-1:0] pos_cnt_q, pos_cnt_d, neg_cnt_q, neg_cnt_d;
  logic          out_valid_q, out_valid_d;

  // Working registers.
  logic                 side_q, side_d;   // high selects the negative table
  logic                 kind_q, kind_d;   // high for a thrust-from-speed query
  logic                 app_q, app_d;
  logic                 mneg_q, mneg_d;   // negate the final result (mirroring)
  logic                 first_q, first_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic signed [VW-1:0] t_q, t_d, s_q, s_d;
  logic signed [XW-1:0] x_q, x_d;
  logic signed [XW-1:0] ld_q, ld_d, lv_q, lv_d, rd_q, rd_d, rv_q, rv_d;
  logic signed [XW-1:0] a_q, a_d, b_q, b_d, d_q, d_d, base_q, base_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [QW-1:0] quot_q, quot_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic [2:0]           st_q, st_d;
  logic signed [VW-1:0] out_val_q, out_val_d;
  logic [2:0]           out_st_q, out_st_d;

  // Breakpoint memories, {thrust, speed} per entry.
  logic [EW-1:0] pos_mem [MAX_POINTS];
  logic [EW-1:0] neg_mem [MAX_POINTS];
  logic [EW-1:0] pos_rd_q, neg_rd_q;
  logic          wr_pos, wr_neg;

  // Helper signals.
  logic                 go_pos;
  logic signed [VW-1:0] key_in;
  logic signed [XW-1:0] key_x;
  logic [AW-1:0]        pos_last, neg_last;
  logic [EW-1:0]        entry;
  logic signed [VW-1:0] e_thr, e_spd;
  logic signed [XW-1:0] e_thr_x, e_spd_x, low_x, high_x;
  logic                 early, cond, last;
  logic signed [XW-1:0] early_val;
  logic signed [XW-1:0] run, rise;
  logic signed [SW-1:0] res;
  logic signed [VW-1:0] res_sat;

  logic                 div_start, div_done;
  logic signed [QW-1:0] div_quo;

  plmap_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (d_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // APB register file. Writes complete in the access phase; no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_low_q    <= DefLowLimit;
      cfg_high_q   <= DefHighLimit;
      cfg_factor_q <= '0;
      cfg_mirror_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LOW:    cfg_low_q    <= pwdata[VW-1:0];
        REG_HIGH:   cfg_high_q   <= pwdata[VW-1:0];
        REG_FACTOR: cfg_factor_q <= pwdata[VW-1:0];
        REG_MIRROR: cfg_mirror_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOW:    prdata = {{(32 - VW){cfg_low_q[VW-1]}}, cfg_low_q};
      REG_HIGH:   prdata = {{(32 - VW){cfg_high_q[VW-1]}}, cfg_high_q};
      REG_FACTOR: prdata = {{(32 - VW){1'b0}}, cfg_factor_q};
      REG_MIRROR: prdata = {31'd0, cfg_mirror_q};
      default:    prdata = '0;
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (wr_pos) begin
      pos_mem[AW'(pos_cnt_q)] <= {t_q, s_q};
    end
    if (wr_neg) begin
      neg_mem[AW'(neg_cnt_q)] <= {t_q, s_q};
    end
    pos_rd_q <= pos_mem[rd_idx_q];
    neg_rd_q <= neg_mem[rd_idx_q];
  end

  assign key_in   = (req_type_i == REQ_SPEED) ? thrust_in_i : speed_in_i;
  assign key_x    = XW'(key_in);
  assign pos_last = AW'(pos_cnt_q - CW'(1));
  assign neg_last = AW'(neg_cnt_q - CW'(1));

  assign entry   = side_q ? neg_rd_q : pos_rd_q;
  assign e_thr   = entry[EW-1:VW];
  assign e_spd   = entry[VW-1:0];
  assign e_thr_x = XW'(e_thr);
  assign e_spd_x = XW'(e_spd);
  assign low_x   = XW'(cfg_low_q);
  assign high_x  = XW'(cfg_high_q);

  // The positive table is walked downward from its last entry, the negative
  // table upward from its first. The first entry visited also decides the
  // clamp beyond the outer limit.
  always_comb begin
    if (!side_q) begin
      early     = first_q && (kind_q ? (x_q >= e_spd_x) : (x_q >= high_x));
      early_val = kind_q ? high_x : e_spd_x;
      cond      = kind_q ? (x_q > e_spd_x) : (x_q >= e_thr_x);
      last      = (rd_idx_q == '0);
    end else begin
      early     = first_q && (kind_q ? (x_q <= e_spd_x) : (x_q <= low_x));
      early_val = kind_q ? low_x : e_spd_x;
      cond      = kind_q ? (x_q <= e_spd_x) : (x_q <= e_thr_x);
      last      = (rd_idx_q == neg_last);
    end
  end

  assign run  = rd_q - ld_q;
  assign rise = rv_q - lv_q;

  // Final value: optional negation for the mirrored side, then saturation.
  assign res = mneg_q ? -sum_q : sum_q;
  always_comb begin
    if (res > SatHi) begin
      res_sat = VW'(SatHi);
    end else if (res < SatLo) begin
      res_sat = VW'(SatLo);
    end else begin
      res_sat = res[VW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    pos_cnt_d   = pos_cnt_q;
    neg_cnt_d   = neg_cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    side_d      = side_q;
    kind_d      = kind_q;
    app_d       = app_q;
    mneg_d      = mneg_q;
    first_d     = first_q;
    rd_idx_d    = rd_idx_q;
    t_d         = t_q;
    s_d         = s_q;
    x_d         = x_q;
    ld_d        = ld_q;
    lv_d        = lv_q;
    rd_d        = rd_q;
    rv_d        = rv_q;
    a_d         = a_q;
    b_d         = b_q;
    d_d         = d_q;
    base_d      = base_q;
    prod_d      = prod_q;
    quot_d      = quot_q;
    sum_d       = sum_q;
    st_d        = st_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    wr_pos      = 1'b0;
    wr_neg      = 1'b0;
    div_start   = 1'b0;
    go_pos      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t_d     = thrust_in_i;
          s_d     = speed_in_i;
          quot_d  = '0;
          base_d  = '0;
          st_d    = ST_OK;
          mneg_d  = 1'b0;
          first_d = 1'b1;
          app_d   = 1'b0;
          kind_d  = (req_type_i == REQ_THRUST);
          state_d = S_FIN;
          case (req_type_i)
            REQ_CLEAR: begin
              pos_cnt_d = '0;
              neg_cnt_d = '0;
            end
            REQ_APPEND: begin
              app_d = 1'b1;
              if (thrust_in_i < cfg_low_q || thrust_in_i > cfg_high_q) begin
                st_d = ST_RANGE;
              end else if (thrust_in_i > 0) begin
                side_d = 1'b0;
                if (speed_in_i < 0) begin
                  st_d = ST_SIGN;
                end else if (pos_cnt_q == CW'(MAX_POINTS)) begin
                  st_d = ST_FULL;
                end else begin
                  first_d  = (pos_cnt_q != '0);
                  rd_idx_d = pos_last;
                  state_d  = (pos_cnt_q != '0) ? S_RD : S_APP;
                end
              end else if (thrust_in_i < 0) begin
                side_d = 1'b1;
                if (speed_in_i > 0) begin
                  st_d = ST_SIGN;
                end else if (neg_cnt_q == CW'(MAX_POINTS)) begin
                  st_d = ST_FULL;
                end else begin
                  first_d  = (neg_cnt_q != '0);
                  rd_idx_d = neg_last;
                  state_d  = (neg_cnt_q != '0) ? S_RD : S_APP;
                end
              end else if (speed_in_i != 0) begin
                st_d = ST_SIGN;
              end
            end
            default: begin
              if (key_in > 0) begin
                side_d = 1'b0;
                x_d    = key_x;
                go_pos = 1'b1;
              end else if (key_in < 0) begin
                if (neg_cnt_q != '0) begin
                  side_d   = 1'b1;
                  x_d      = key_x;
                  rd_idx_d = '0;
                  state_d  = S_RD;
                end else if (cfg_mirror_q) begin
                  side_d = 1'b0;
                  x_d    = -key_x;
                  mneg_d = 1'b1;
                  go_pos = 1'b1;
                end
              end
              if (go_pos) begin
                if (pos_cnt_q != '0) begin
                  rd_idx_d = pos_last;
                  state_d  = S_RD;
                end else if (cfg_factor_q != '0) begin
                  // Linear mode: speed = thrust*256/factor or
                  // thrust = speed*factor/256, both positive here.
                  a_d     = x_d;
                  b_d     = kind_d ? $signed({2'b00, cfg_factor_q}) : XW'(256);
                  d_d     = kind_d ? XW'(256) : $signed({2'b00, cfg_factor_q});
                  state_d = S_MUL;
                end
              end
            end
          endcase
        end
      end

      S_RD: begin
        state_d = app_q ? S_APP : S_EV;
      end

      S_APP: begin
        state_d = S_FIN;
        if (first_q && t_q <= e_thr) begin
          st_d = ST_ORDER;
        end else if (first_q && s_q < e_spd) begin
          st_d = ST_NONASC;
        end else if (side_q) begin
          wr_neg    = 1'b1;
          neg_cnt_d = neg_cnt_q + CW'(1);
        end else begin
          wr_pos    = 1'b1;
          pos_cnt_d = pos_cnt_q + CW'(1);
        end
      end

      S_EV: begin
        first_d = 1'b0;
        if (first_q) begin
          if (!side_q) begin
            rd_d = high_x;
            rv_d = e_spd_x;
          end else begin
            ld_d = low_x;
            lv_d = e_spd_x;
          end
        end
        if (early) begin
          base_d  = early_val;
          state_d = S_FIN;
        end else begin
          if (!side_q) begin
            if (cond) begin
              ld_d = e_thr_x;
              lv_d = e_spd_x;
            end else begin
              rd_d = e_thr_x;
              rv_d = e_spd_x;
              if (last) begin
                ld_d = '0;
                lv_d = '0;
              end
            end
          end else begin
            if (cond) begin
              rd_d = e_thr_x;
              rv_d = e_spd_x;
            end else begin
              ld_d = e_thr_x;
              lv_d = e_spd_x;
              if (last) begin
                rd_d = '0;
                rv_d = '0;
              end
            end
          end
          if (cond || last) begin
            state_d = S_SEG;
          end else begin
            rd_idx_d = side_q ? rd_idx_q + AW'(1) : rd_idx_q - AW'(1);
            state_d  = S_RD;
          end
        end
      end

      S_SEG: begin
        if (run <= 0) begin
          base_d  = '0;
          state_d = S_FIN;
        end else if (!kind_q) begin
          a_d     = x_q - ld_q;
          b_d     = rise;
          d_d     = run;
          base_d  = lv_q;
          state_d = S_MUL;
        end else if (rise == 0) begin
          // Flat segment: answer with its left thrust.
          base_d  = ld_q;
          state_d = S_FIN;
        end else begin
          a_d     = x_q - lv_q;
          b_d     = run;
          d_d     = rise;
          base_d  = ld_q;
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        prod_d  = a_q * b_q;
        state_d = S_DST;
      end

      S_DST: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          quot_d  = div_quo;
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        sum_d   = SW'(base_q) + SW'(quot_q);
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_val_d   = res_sat;
          out_st_d    = st_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_cnt_q   <= '0;
      neg_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_cnt_q   <= pos_cnt_d;
      neg_cnt_q   <= neg_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q    <= side_d;
    kind_q    <= kind_d;
    app_q     <= app_d;
    mneg_q    <= mneg_d;
    first_q   <= first_d;
    rd_idx_q  <= rd_idx_d;
    t_q       <= t_d;
    s_q       <= s_d;
    x_q       <= x_d;
    ld_q      <= ld_d;
    lv_q      <= lv_d;
    rd_q      <= rd_d;
    rv_q      <= rv_d;
    a_q       <= a_d;
    b_q       <= b_d;
    d_q       <= d_d;
    base_q    <= base_d;
    prod_q    <= prod_d;
    quot_q    <= quot_d;
    sum_q     <= sum_d;
    st_q      <= st_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_out_o = out_val_q;
  assign status_o    = out_st_q;

  // Table counts never exceed the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_cnt_q <= CW'(MAX_POINTS) && neg_cnt_q <= CW'(MAX_POINTS))
    else $error("breakpoint count beyond table depth");

  // The positive count only clears or grows by one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_cnt_q != $past(pos_cnt_q)) |->
      (pos_cnt_q == '0 || pos_cnt_q == $past(pos_cnt_q) + CW'(1)))
    else $error("positive count changed by more than one");

  // After accepting a request the sequencer is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in work");

  // The divider reports completion only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

  // Loading the output register returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || out_ready_i)) |=> (out_valid_o && in_ready_o))
    else $error("result not presented after completion");

endmodule

@@ test/piecewise_linear_thrust_speed_map_tb.sv @@
module piecewise_linear_thrust_speed_map_tb;
  import plmap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TablePoints = 16;
  localparam int HoldCycles  = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // APB side of the block.
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  // Request and result channels.
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           req_type_i = REQ_CLEAR;
  logic signed [VW-1:0] thrust_in_i = '0;
  logic signed [VW-1:0] speed_in_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [VW-1:0] value_out_o;
  logic [2:0]           status_o;

  piecewise_linear_thrust_speed_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .thrust_in_i (thrust_in_i),
    .speed_in_i  (speed_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_out_o (value_out_o),
    .status_o    (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // One expected result transaction: a value and its status code.
  typedef struct {
    logic signed [VW-1:0] value;
    logic [2:0]           status;
  } map_result_t;

  map_result_t expected_results[$];
  int          error_count = 0;

  // Shadow copy of the registers and of the two breakpoint tables. The tables
  // are only ever read below their counts, exactly like the block.
  int lo_limit;
  int hi_limit;
  int factor;
  bit mirror;
  int pos_thrust[TablePoints];
  int pos_speed[TablePoints];
  int neg_thrust[TablePoints];
  int neg_speed[TablePoints];
  int pos_fill;
  int neg_fill;

  function automatic logic signed [VW-1:0] saturate(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return VW'(v);
  endfunction

  // Linear interpolation of speed along one segment; a segment whose run is
  // not positive answers zero. Integer division truncates toward zero.
  function automatic longint lerp_speed(int t, int ld, int lv, int rd, int rv);
    longint run;
    run = longint'(rd) - ld;
    if (run <= 0) return 0;
    return longint'(lv) + ((longint'(t) - ld) * (longint'(rv) - lv)) / run;
  endfunction

  // Inverse interpolation: a flat segment answers its left thrust.
  function automatic longint lerp_thrust(int s, int ld, int lv, int rd, int rv);
    longint run;
    longint rise;
    run = longint'(rd) - ld;
    rise = longint'(rv) - lv;
    if (run <= 0) return 0;
    if (rise == 0) return ld;
    return longint'(ld) + ((longint'(s) - lv) * run) / rise;
  endfunction

  function automatic longint speed_for_pos(int t);
    int i;
    int ld = 0;
    int lv = 0;
    int rd;
    int rv;
    if (pos_fill == 0) begin
      if (factor == 0) return 0;
      return (longint'(t) * 256) / longint'(factor);
    end
    i = pos_fill - 1;
    rd = hi_limit;
    rv = pos_speed[i];
    if (t >= hi_limit) return rv;
    for (; i >= 0; i--) begin
      if (t >= pos_thrust[i]) begin
        ld = pos_thrust[i];
        lv = pos_speed[i];
        break;
      end
      rd = pos_thrust[i];
      rv = pos_speed[i];
    end
    return lerp_speed(t, ld, lv, rd, rv);
  endfunction

  function automatic longint speed_for_neg(int t);
    int ld;
    int lv;
    int rd = 0;
    int rv = 0;
    if (neg_fill == 0) return mirror ? -speed_for_pos(-t) : 0;
    ld = lo_limit;
    lv = neg_speed[0];
    if (t <= lo_limit) return lv;
    for (int i = 0; i < neg_fill; i++) begin
      if (t <= neg_thrust[i]) begin
        rd = neg_thrust[i];
        rv = neg_speed[i];
        break;
      end
      ld = neg_thrust[i];
      lv = neg_speed[i];
    end
    return lerp_speed(t, ld, lv, rd, rv);
  endfunction

  function automatic longint thrust_for_pos(int s);
    int i;
    int ld = 0;
    int lv = 0;
    int rd;
    int rv;
    if (pos_fill == 0) begin
      if (factor == 0) return 0;
      return (longint'(s) * longint'(factor)) / 256;
    end
    i = pos_fill - 1;
    rd = hi_limit;
    rv = pos_speed[i];
    if (s >= rv) return hi_limit;
    for (; i >= 0; i--) begin
      if (s > pos_speed[i]) begin
        ld = pos_thrust[i];
        lv = pos_speed[i];
        break;
      end
      rd = pos_thrust[i];
      rv = pos_speed[i];
    end
    return lerp_thrust(s, ld, lv, rd, rv);
  endfunction

  function automatic longint thrust_for_neg(int s);
    int ld;
    int lv;
    int rd = 0;
    int rv = 0;
    if (neg_fill == 0) return mirror ? -thrust_for_pos(-s) : 0;
    ld = lo_limit;
    lv = neg_speed[0];
    if (s <= lv) return lo_limit;
    for (int i = 0; i < neg_fill; i++) begin
      if (s <= neg_speed[i]) begin
        rd = neg_thrust[i];
        rv = neg_speed[i];
        break;
      end
      ld = neg_thrust[i];
      lv = neg_speed[i];
    end
    return lerp_thrust(s, ld, lv, rd, rv);
  endfunction

  // Checks run in a fixed order: range, sign, room, thrust order, speed order.
  // A rejected pair leaves the tables untouched.
  function automatic logic [2:0] store_breakpoint(int t, int s);
    if (t < lo_limit || t > hi_limit) return ST_RANGE;
    if (t > 0) begin
      if (s < 0) return ST_SIGN;
      if (pos_fill >= TablePoints) return ST_FULL;
      if (pos_fill > 0) begin
        if (t <= pos_thrust[pos_fill-1]) return ST_ORDER;
        if (s < pos_speed[pos_fill-1]) return ST_NONASC;
      end
      pos_thrust[pos_fill] = t;
      pos_speed[pos_fill] = s;
      pos_fill++;
    end else if (t < 0) begin
      if (s > 0) return ST_SIGN;
      if (neg_fill >= TablePoints) return ST_FULL;
      if (neg_fill > 0) begin
        if (t <= neg_thrust[neg_fill-1]) return ST_ORDER;
        if (s < neg_speed[neg_fill-1]) return ST_NONASC;
      end
      neg_thrust[neg_fill] = t;
      neg_speed[neg_fill] = s;
      neg_fill++;
    end else if (s != 0) begin
      return ST_SIGN;
    end
    return ST_OK;
  endfunction

  function automatic map_result_t map_request(logic [1:0] req, int t, int s);
    map_result_t r;
    longint v = 0;
    r.status = ST_OK;
    case (req)
      REQ_CLEAR: begin
        pos_fill = 0;
        neg_fill = 0;
      end
      REQ_APPEND: r.status = store_breakpoint(t, s);
      REQ_SPEED: begin
        if (t > 0) v = speed_for_pos(t);
        else if (t < 0) v = speed_for_neg(t);
      end
      default: begin
        if (s > 0) v = thrust_for_pos(s);
        else if (s < 0) v = thrust_for_neg(s);
      end
    endcase
    r.value = saturate(v);
    return r;
  endfunction

  // Directed rows. Where typed is set the expected value and status come from
  // the row itself; the model is still run so its tables stay in step.
  typedef struct {
    logic [1:0]           req;
    logic signed [VW-1:0] thrust;
    logic signed [VW-1:0] speed;
    bit                   typed;
    logic signed [VW-1:0] value;
    logic [2:0]           status;
  } request_row_t;

  request_row_t directed_rows[$];
  bit           typed_pending[$];
  map_result_t  typed_values[$];

  // Monitor: an accepted request gets its expectation, an accepted result is
  // compared with the oldest one.
  always @(posedge clk_i) begin
    map_result_t want;
    map_result_t model;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction value=%0d status=%0d",
                 $time, value_out_o, status_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (value_out_o !== want.value) begin
          $display("%0t: value mismatch expected=%0d actual=%0d",
                   $time, want.value, value_out_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d",
                   $time, want.status, status_o);
          error_count++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      model = map_request(req_type_i, int'(thrust_in_i), int'(speed_in_i));
      if (typed_pending.size() != 0 && typed_pending.pop_front()) begin
        model = typed_values.pop_front();
      end
      expected_results.push_back(model);
    end
  end

  // Receiver: stalls on a mode-dependent pattern, and on request holds ready
  // low for a long stretch so the block backs up into its request channel.
  int rx_mode = 0;
  bit hold_request = 1'b0;
  int hold_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_request) begin
      out_ready_i <= 1'b0;
      hold_count++;
      if (hold_count >= HoldCycles) begin
        hold_request = 1'b0;
        hold_count = 0;
      end
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom % 4) != 0;
        default: out_ready_i <= ($urandom % 3) == 0;
      endcase
    end
  end

  // Sender: bursts of random length separated by random gaps; in mode zero it
  // never pauses.
  int tx_mode = 1;
  int burst_left = 0;

  task automatic send_request(logic [1:0] req, int t, int s, bit typed = 0,
                              map_result_t typed_value = '{0, ST_OK});
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (tx_mode == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    typed_pending.push_back(typed);
    if (typed) typed_values.push_back(typed_value);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    thrust_in_i <= VW'(t);
    speed_in_i <= VW'(s);
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  // Stops offering requests and waits until every result is back, plus the
  // longest query latency so the block is surely idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // A register is written at the access edge; the shadow copy follows there.
  task automatic write_register(logic [1:0] index, int value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * index);
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_LOW: lo_limit = int'($signed(value[15:0]));
      REG_HIGH: hi_limit = int'($signed(value[15:0]));
      REG_FACTOR: factor = value & 16'hffff;
      default: mirror = value[0];
    endcase
  endtask

  task automatic write_settings(int lo, int hi, int fac, int mir);
    write_register(REG_LOW, lo);
    write_register(REG_HIGH, hi);
    write_register(REG_FACTOR, fac);
    write_register(REG_MIRROR, mir);
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // A query either covers the whole 16-bit range or stays near the limits,
  // where the breakpoints live.
  task automatic send_query();
    int t;
    int s;
    if ($urandom % 2) begin
      t = $urandom_range(0, 65535) - 32768;
      s = $urandom_range(0, 65535) - 32768;
    end else begin
      t = $urandom_range(0, 2 * 25600) - 25600;
      s = $urandom_range(0, 2 * 12000) - 12000;
    end
    send_request(($urandom % 2) ? REQ_SPEED : REQ_THRUST, t, s);
  endtask

  // A well-formed table: ascending thrust within the limits and nondecreasing
  // speed on each side, now and then broken on purpose, with queries mixed in.
  // Counts run past the table depth so a full table is reached too.
  task automatic build_tables(ref int sent);
    int n_pos;
    int n_neg;
    int pt;
    int ps;
    int nt;
    int ns;
    int t;
    int s;
    int span;
    if ($urandom % 10 < 7) begin
      send_request(REQ_CLEAR, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535));
      sent++;
    end
    n_pos = $urandom_range(0, 18);
    n_neg = $urandom_range(0, 18);
    pt = 0;
    ps = 0;
    nt = (lo_limit < 0) ? lo_limit - 1 : -32769;
    ns = -$urandom_range(0, 30000);
    for (int k = 0; k < n_pos || k < n_neg; k++) begin
      if (k < n_pos) begin
        span = (hi_limit - pt) / (n_pos - k + 1);
        t = clamp16(pt + $urandom_range(1, (span > 1) ? span : 1));
        s = clamp16(ps + $urandom_range(0, 2500));
        if ($urandom % 12 == 0) s = ps - $urandom_range(1, 300);
        if ($urandom % 15 == 0) t = pt;
        if ($urandom % 20 == 0) s = -s - 1;
        send_request(REQ_APPEND, t, s);
        sent++;
        pt = t;
        ps = (s > ps) ? s : ps;
      end
      if (k < n_neg) begin
        span = (0 - nt) / (n_neg - k + 1);
        t = clamp16(nt + $urandom_range(1, (span > 1) ? span : 1));
        if (t >= 0) t = -1;
        s = ns + $urandom_range(0, 2500);
        if (s > 0) s = 0;
        if ($urandom % 12 == 0) s = ns - $urandom_range(1, 300);
        if ($urandom % 15 == 0) t = nt;
        if ($urandom % 20 == 0) s = 1 + $urandom_range(0, 100);
        send_request(REQ_APPEND, t, clamp16(s));
        sent++;
        nt = t;
        ns = (clamp16(s) > ns && s <= 0) ? clamp16(s) : ns;
      end
      if ($urandom % 3 == 0) begin
        send_query();
        sent++;
      end
    end
    repeat ($urandom_range(4, 12)) begin
      send_query();
      sent++;
    end
  endtask

  // Unstructured requests: every field bit sees both values.
  task automatic send_noise(ref int sent);
    send_request(2'($urandom), $urandom_range(0, 65535) - 32768,
                 $urandom_range(0, 65535) - 32768);
    sent++;
  endtask

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    map_result_t tv;
    int sent;
    lo_limit = int'(DefLowLimit);
    hi_limit = int'(DefHighLimit);
    factor = 0;
    mirror = 1'b0;
    pos_fill = 0;
    neg_fill = 0;

    // Directed walk with reset limits of -25600 and 25600.
    directed_rows = '{
      '{REQ_SPEED,  16'sd100,    16'sd0,     1, 16'sd0,     ST_OK},
      '{REQ_THRUST, 16'sd0,      16'sd300,   1, 16'sd0,     ST_OK},
      '{REQ_CLEAR,  16'sd0,      16'sd0,     1, 16'sd0,     ST_OK},
      '{REQ_APPEND, 16'sd32767,  16'sd10,    1, 16'sd0,     ST_RANGE},
      '{REQ_APPEND, -16'sd32768, -16'sd10,   1, 16'sd0,     ST_RANGE},
      '{REQ_APPEND, 16'sd256,    -16'sd1,    1, 16'sd0,     ST_SIGN},
      '{REQ_APPEND, 16'sd0,      16'sd5,     1, 16'sd0,     ST_SIGN},
      '{REQ_APPEND, 16'sd0,      16'sd0,     1, 16'sd0,     ST_OK},
      '{REQ_APPEND, 16'sd2560,   16'sd512,   1, 16'sd0,     ST_OK},
      '{REQ_APPEND, 16'sd2560,   16'sd600,   1, 16'sd0,     ST_ORDER},
      '{REQ_APPEND, 16'sd5120,   16'sd100,   1, 16'sd0,     ST_NONASC},
      '{REQ_APPEND, 16'sd5120,   16'sd1024,  1, 16'sd0,     ST_OK},
      '{REQ_SPEED,  -16'sd32768, 16'sd0,     1, 16'sd0,     ST_OK},
      '{REQ_SPEED,  16'sd32767,  16'sd0,     1, 16'sd1024,  ST_OK},
      '{REQ_THRUST, 16'sd0,      16'sd32767, 1, 16'sd25600, ST_OK},
      '{REQ_SPEED,  16'sd1280,   16'sd0,     0, 16'sd0,     ST_OK},
      '{REQ_THRUST, 16'sd0,      16'sd700,   0, 16'sd0,     ST_OK},
      '{REQ_APPEND, -16'sd2560,  -16'sd512,  1, 16'sd0,     ST_OK},
      '{REQ_APPEND, -16'sd5120,  -16'sd1024, 1, 16'sd0,     ST_ORDER},
      '{REQ_APPEND, -16'sd1280,  -16'sd1000, 1, 16'sd0,     ST_NONASC},
      '{REQ_APPEND, -16'sd1280,  -16'sd256,  1, 16'sd0,     ST_OK},
      '{REQ_SPEED,  -16'sd32768, 16'sd0,     1, -16'sd512,  ST_OK},
      '{REQ_THRUST, 16'sd0,      -16'sd32768, 1, -16'sd25600, ST_OK},
      '{REQ_SPEED,  -16'sd1920,  16'sd0,     0, 16'sd0,     ST_OK},
      '{REQ_CLEAR,  16'sd0,      16'sd0,     1, 16'sd0,     ST_OK}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rx_mode = 1;
    foreach (directed_rows[i]) begin
      tv.value = directed_rows[i].value;
      tv.status = directed_rows[i].status;
      send_request(directed_rows[i].req, directed_rows[i].thrust,
                   directed_rows[i].speed, directed_rows[i].typed, tv);
    end
    drain_results();

    // Random phases, each under its own register setting. Every phase ends
    // with the sender paused until all results are back.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_settings(-25600, 25600, 0, 0);
        1: write_settings(-32768, 32767, 65535, 1);
        2: write_settings(-256, 256, 1, 0);
        3: write_settings(-25600, 25600, 256, 1);
        4: write_settings(0, -1, 0, 1);
        5: write_settings(-12800, 32767, 0, 1);
        default: write_settings($urandom_range(0, 32767) - 32768, $urandom_range(0, 32767),
                                $urandom_range(0, 65535), $urandom % 2);
      endcase
      rx_mode = phase % 3;
      tx_mode = (phase == 2) ? 0 : 1;
      // Long receiver hold while the sender keeps offering requests.
      if (phase == 3) hold_request = 1'b1;
      sent = 0;
      while (sent < 66) begin
        if ($urandom % 10 < 7) build_tables(sent);
        else send_noise(sent);
      end
      drain_results();
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
